/* design/smtp_clr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smtp_clr_pkg
// Shared types and constants of the smtp command line recognizer.
// ----------------------------------------------------------------------------
package smtp_clr_pkg;

    localparam int BUFFER_BYTES = 4096;
    localparam int LEN_W        = $clog2(BUFFER_BYTES);

    typedef enum logic [1:0] {
        MODE_CLOSED  = 2'd0,
        MODE_COMMAND = 2'd1,
        MODE_MESSAGE = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        RK_OK      = 4'd0,
        RK_RCPT    = 4'd1,
        RK_CONT    = 4'd2,
        RK_RESET   = 4'd3,
        RK_NOOP    = 4'd4,
        RK_BYE     = 4'd5,
        RK_NOTIMP  = 4'd6,
        RK_TOOLONG = 4'd7,
        RK_GREET   = 4'd8
    } reply_kind_t;

    typedef enum logic {
        CMD_BYTE  = 1'b0,
        CMD_START = 1'b1
    } cmd_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0] reply_kind;
        logic       session_closed;
    } out_item_t;

    typedef struct packed {
        logic      has_result;
        out_item_t result;
    } decision_t;

endpackage : smtp_clr_pkg
`default_nettype wire

/* design/smtp_command_line_recognizer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smtp_command_line_recognizer_core
// Splits a mail session byte stream into lines and answers each command.
// ----------------------------------------------------------------------------
// One byte or session-start item is taken per clock cycle while the byte side
// does not stall. An item sits in the input register while the line state is
// updated and its reply, if any, is written into the result register, from
// which it is offered on the reply side. The pair of registers keeps a full
// cycle-per-item rate while the reply side does not stall; a stalled reply
// holds the input register, which in turn stalls the byte side.
module smtp_command_line_recognizer_core
    import smtp_clr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_stall,
    input  wire in_item_t  byte_item,
    output logic           reply_valid,
    input  wire logic      reply_stall,
    output out_item_t      reply_item
);

    logic      item_valid_reg, item_valid_next;
    in_item_t  item_reg;
    logic      reply_valid_reg, reply_valid_next;
    out_item_t reply_item_reg;
    logic      fire;
    decision_t decision;

    // the input register moves on when the result slot is free or being taken
    assign fire       = item_valid_reg && (!reply_valid_reg || !reply_stall);
    assign byte_stall = item_valid_reg && !fire;

    assign item_valid_next  = (byte_valid && !byte_stall) || (item_valid_reg && !fire);
    assign reply_valid_next = fire ? decision.has_result : (reply_valid_reg && reply_stall);

    smtp_clr_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_reg),
        .fire     (fire),
        .decision (decision)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg  <= 1'b0;
            reply_valid_reg <= 1'b0;
        end else begin
            item_valid_reg  <= item_valid_next;
            reply_valid_reg <= reply_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall) begin
            item_reg <= byte_item;
        end
        if (fire && decision.has_result) begin
            reply_item_reg <= decision.result;
        end
    end

    assign reply_valid = reply_valid_reg;
    assign reply_item  = reply_item_reg;

endmodule : smtp_command_line_recognizer_core
`default_nettype wire

/* design/smtp_clr_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smtp_clr_parser
// Session and line state with the per-byte decision logic.
// ----------------------------------------------------------------------------
module smtp_clr_parser
    import smtp_clr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_item_t  item,
    input  wire logic      fire,
    output decision_t      decision
);

    localparam logic [31:0] W_HELO = 32'h4F4C4548;
    localparam logic [31:0] W_MAIL = 32'h4C49414D;
    localparam logic [31:0] W_RCPT = 32'h54504352;
    localparam logic [31:0] W_DATA = 32'h41544144;
    localparam logic [31:0] W_RSET = 32'h54455352;
    localparam logic [31:0] W_NOOP = 32'h504F4F4E;
    localparam logic [31:0] W_QUIT = 32'h54495551;
    localparam logic [7:0]  CH_CR  = 8'h0D;
    localparam logic [7:0]  CH_LF  = 8'h0A;
    localparam logic [7:0]  CH_DOT = 8'h2E;

    mode_t              mode_reg, mode_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [31:0]        lead_reg, lead_next;
    logic               cr_reg, cr_next;
    logic [LEN_W-1:0]   len_inc;
    logic [31:0]        folded;

    function automatic logic [31:0] fold_upper(input logic [31:0] w);
        logic [31:0] r;
        logic [7:0]  ch;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            ch = w[8*k +: 8];
            if (ch >= 8'h61 && ch <= 8'h7A) begin
                ch = ch - 8'h20;
            end
            r[8*k +: 8] = ch;
        end
        return r;
    endfunction

    assign len_inc = len_reg + LEN_W'(1);
    assign folded  = fold_upper(lead_reg);

    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        lead_next = lead_reg;
        cr_next   = cr_reg;
        decision  = '0;
        decision.result.reply_kind = RK_OK;
        if (item.cmd == CMD_START) begin
            mode_next = MODE_COMMAND;
            len_next  = '0;
            lead_next = '0;
            cr_next   = 1'b0;
            decision.has_result        = 1'b1;
            decision.result.reply_kind = RK_GREET;
        end else begin
            case (mode_reg)
                MODE_COMMAND, MODE_MESSAGE:
                begin
                    if (item.data_byte == CH_LF && cr_reg) begin
                        // line closed; stored length still counts the cr
                        len_next  = '0;
                        lead_next = '0;
                        cr_next   = 1'b0;
                        if (mode_reg == MODE_MESSAGE) begin
                            if (len_reg == LEN_W'(2) && lead_reg[7:0] == CH_DOT) begin
                                mode_next           = MODE_COMMAND;
                                decision.has_result = 1'b1;
                            end
                        end else begin
                            decision.has_result        = 1'b1;
                            decision.result.reply_kind = RK_NOTIMP;
                            if (len_reg == LEN_W'(5)) begin
                                case (folded)
                                    W_HELO, W_MAIL: decision.result.reply_kind = RK_OK;
                                    W_RCPT:         decision.result.reply_kind = RK_RCPT;
                                    W_DATA:
                                    begin
                                        decision.result.reply_kind = RK_CONT;
                                        mode_next = MODE_MESSAGE;
                                    end
                                    W_RSET:         decision.result.reply_kind = RK_RESET;
                                    W_NOOP:         decision.result.reply_kind = RK_NOOP;
                                    W_QUIT:
                                    begin
                                        decision.result.reply_kind     = RK_BYE;
                                        decision.result.session_closed = 1'b1;
                                        mode_next = MODE_CLOSED;
                                    end
                                    default:        decision.result.reply_kind = RK_NOTIMP;
                                endcase
                            end
                        end
                    end else begin
                        if (len_reg < LEN_W'(4)) begin
                            lead_next = lead_reg
                                      | ({24'b0, item.data_byte} << {len_reg[1:0], 3'b000});
                        end
                        len_next = len_inc;
                        cr_next  = (item.data_byte == CH_CR);
                        if (len_inc == LEN_W'(BUFFER_BYTES - 1)) begin
                            len_next  = '0;
                            lead_next = '0;
                            cr_next   = 1'b0;
                            decision.has_result        = 1'b1;
                            decision.result.reply_kind = RK_TOOLONG;
                        end
                    end
                end
                default:
                begin
                    // closed session: bytes are dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_CLOSED;
            len_reg  <= '0;
            lead_reg <= '0;
            cr_reg   <= 1'b0;
        end else if (fire) begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            lead_reg <= lead_next;
            cr_reg   <= cr_next;
        end
    end

endmodule : smtp_clr_parser
`default_nettype wire

/* verif/smtp_command_line_recognizer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smtp_command_line_recognizer_core_tb
// Drives mail session byte streams into the recognizer and predicts every
// reply from a line-level model of the session. Replies are checked in order,
// field by field. Both handshake sides idle at random, and one phase holds
// the reply side off while bytes keep arriving, so the byte side stalls.
// ----------------------------------------------------------------------------
module smtp_command_line_recognizer_core_tb;
    import smtp_clr_pkg::*;

    localparam int RANDOM_ITEMS  = 1550;
    localparam int IDLE_MAX      = 12;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REPORT_MAX    = 10;

    localparam logic [7:0] ASCII_CR  = 8'h0D;
    localparam logic [7:0] ASCII_LF  = 8'h0A;
    localparam logic [7:0] ASCII_DOT = 8'h2E;

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      byte_valid  = 1'b0;
    logic      byte_stall;
    in_item_t  byte_item   = '0;
    logic      reply_valid;
    logic      reply_stall = 1'b0;
    out_item_t reply_item;

    // line state of the session as the predictor sees it
    mode_t            sess_mode  = MODE_CLOSED;
    logic [LEN_W-1:0] line_len   = '0;
    logic [31:0]      line_head  = '0;
    logic             pending_cr = 1'b0;

    out_item_t expected_replies[$];
    int        mismatch_count = 0;
    int        live_items     = 0;
    int        send_idle_max  = 0;
    int        recv_idle_max  = 0;
    int        cycle_count    = 0;
    logic      hold_replies   = 1'b0;
    event      hold_go;

    string command_words[7] = '{"HELO", "MAIL", "RCPT", "DATA", "RSET", "NOOP", "QUIT"};

    smtp_command_line_recognizer_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_item   (byte_item),
        .reply_valid (reply_valid),
        .reply_stall (reply_stall),
        .reply_item  (reply_item)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void queue_reply(reply_kind_t kind, logic closed);
        expected_replies.push_back('{reply_kind: kind, session_closed: closed});
    endfunction

    function automatic void clear_line_state();
        line_len   = '0;
        line_head  = '0;
        pending_cr = 1'b0;
    endfunction

    function automatic void predict_reply(in_item_t it);
        logic [LEN_W-1:0] text_len;
        logic [31:0]      word;
        logic [7:0]       ch;
        if (it.cmd == CMD_START)
        begin
            live_items++;
            sess_mode = MODE_COMMAND;
            clear_line_state();
            queue_reply(RK_GREET, 1'b0);
            return;
        end
        if (sess_mode != MODE_COMMAND && sess_mode != MODE_MESSAGE)
            return;
        live_items++;

        if (it.data_byte == ASCII_LF && pending_cr)
        begin
            text_len = line_len - 1'b1;
            word     = line_head;
            clear_line_state();
            if (sess_mode == MODE_MESSAGE)
            begin
                // the head shifts bytes in, so the dot sits just above the cr
                if (text_len == 1 && word[15:8] == ASCII_DOT)
                begin
                    sess_mode = MODE_COMMAND;
                    queue_reply(RK_OK, 1'b0);
                end
                return;
            end
            if (text_len != 4)
            begin
                queue_reply(RK_NOTIMP, 1'b0);
                return;
            end
            for (int k = 0; k < 4; k++)
            begin
                ch = word[8*k +: 8];
                if (ch >= 8'h61 && ch <= 8'h7A)
                    word[8*k +: 8] = ch - 8'h20;
            end
            case (word)
                "HELO", "MAIL": queue_reply(RK_OK, 1'b0);
                "RCPT":         queue_reply(RK_RCPT, 1'b0);
                "DATA":
                begin
                    sess_mode = MODE_MESSAGE;
                    queue_reply(RK_CONT, 1'b0);
                end
                "RSET":         queue_reply(RK_RESET, 1'b0);
                "NOOP":         queue_reply(RK_NOOP, 1'b0);
                "QUIT":
                begin
                    sess_mode = MODE_CLOSED;
                    queue_reply(RK_BYE, 1'b1);
                end
                default:        queue_reply(RK_NOTIMP, 1'b0);
            endcase
            return;
        end

        // first byte of the line ends up in the top byte once four are in
        if (line_len < 4)
            line_head = {line_head[23:0], it.data_byte};
        line_len++;
        pending_cr = (it.data_byte == ASCII_CR);
        if (line_len >= BUFFER_BYTES - 1)
        begin
            clear_line_state();
            queue_reply(RK_TOOLONG, 1'b0);
        end
    endfunction

    task automatic send_item(input cmd_t c, input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, send_idle_max);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= '{cmd: c, data_byte: b};
        do
        begin
            @(posedge clk);
        end
        while (byte_stall);
        predict_reply(byte_item);
    endtask

    task automatic send_crlf();
        send_item(CMD_BYTE, ASCII_CR);
        send_item(CMD_BYTE, ASCII_LF);
    endtask

    task automatic send_text(input string s, input bit mix_case);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++)
        begin
            ch = s[i];
            if (mix_case && ch >= 8'h41 && ch <= 8'h5A && $urandom_range(0, 1))
                ch = ch | 8'h20;
            send_item(CMD_BYTE, ch);
        end
    endtask

    task automatic send_line(input string s);
        send_text(s, 1'b0);
        send_crlf();
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_item(CMD_BYTE, 8'($urandom));
    endtask

    // bytes that never hold a cr, so no line can close
    task automatic send_filler(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            b = 8'($urandom);
            if (b == ASCII_CR)
                b = 8'h41;
            send_item(CMD_BYTE, b);
        end
    endtask

    task automatic wait_for_replies();
        byte_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic pick_idle();
        send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
        recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
    endtask

    task automatic test_directed_commands();
        send_idle_max = IDLE_MAX;
        recv_idle_max = IDLE_MAX;
        send_line("HELO");
        send_item(CMD_START, 8'hFF);
        send_line("HELO");
        send_line("mail");
        send_line("RcPt");
        send_line("RSET");
        send_line("noop");
        send_line("");
        send_line("HEL");
        send_line("HELO ");
        send_line("XYZW");
        // zero byte is an ordinary character
        send_item(CMD_BYTE, 8'h00);
        send_crlf();
        // cr inside a line, lone lf, then a line of all ones
        send_text("NO", 1'b0);
        send_item(CMD_BYTE, ASCII_CR);
        send_line("OP");
        send_item(CMD_BYTE, ASCII_LF);
        send_crlf();
        send_item(CMD_BYTE, 8'hFF);
        send_crlf();
        send_line("data");
        send_line("HELO");
        send_line("..");
        send_line(".");
        send_line("DATA");
        send_text("ab", 1'b0);
        send_item(CMD_START, 8'h00);
        send_line("QUIT");
        send_line("NOOP");
        send_item(CMD_START, 8'h5A);
    endtask

    task automatic test_line_too_long();
        send_idle_max = 1;
        recv_idle_max = 1;
        send_item(CMD_START, 8'h00);
        // the cr lands on the last slot, so the following lf opens a new line
        send_filler(BUFFER_BYTES - 2);
        send_item(CMD_BYTE, ASCII_CR);
        send_item(CMD_BYTE, ASCII_LF);
        send_crlf();
        send_line("NOOP");
    endtask

    task automatic test_backpressure();
        send_idle_max = 0;
        recv_idle_max = 0;
        send_item(CMD_START, 8'h00);
        wait_for_replies();
        -> hold_go;
        repeat (40) send_line("NOOP");
        wait_for_replies();
        send_idle_max = IDLE_MAX;
        recv_idle_max = IDLE_MAX;
        repeat (10) send_line("RSET");
    endtask

    task automatic test_random_sessions();
        int goal;
        int pick;
        goal = live_items + RANDOM_ITEMS;
        while (live_items < goal)
        begin
            if ($urandom_range(0, 15) == 0)
                pick_idle();
            pick = $urandom_range(0, 99);
            if (sess_mode == MODE_MESSAGE)
            begin
                if (pick < 30)
                    send_line(".");
                else if (pick < 90)
                begin
                    send_noise($urandom_range(0, 10));
                    send_crlf();
                end
                else if (pick < 96)
                    send_noise($urandom_range(1, 6));
                else
                    send_item(CMD_START, 8'($urandom));
            end
            else if (sess_mode == MODE_COMMAND)
            begin
                if (pick < 60)
                begin
                    send_text(command_words[$urandom_range(0, 6)], 1'b1);
                    if ($urandom_range(0, 7) == 0)
                        send_text(" x", 1'b0);
                    send_crlf();
                end
                else if (pick < 70)
                begin
                    repeat (4) send_item(CMD_BYTE, 8'($urandom_range(8'h41, 8'h5A)));
                    send_crlf();
                end
                else if (pick < 85)
                begin
                    send_noise($urandom_range(0, 8));
                    send_crlf();
                end
                else if (pick < 95)
                    send_noise($urandom_range(1, 6));
                else
                    send_item(CMD_START, 8'($urandom));
            end
            else
            begin
                if (pick < 70)
                    send_item(CMD_START, 8'($urandom));
                else
                    send_noise($urandom_range(1, 6));
            end
        end
    endtask

    // reply side: checks each transfer, then draws its next stall
    initial
    begin
        int        stall_left;
        out_item_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && reply_valid && !reply_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected reply: kind %0d closed %0b",
                                 reply_item.reply_kind, reply_item.session_closed);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (reply_item.reply_kind !== want.reply_kind ||
                        reply_item.session_closed !== want.session_closed)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("reply mismatch: expected kind %0d closed %0b, got kind %0d closed %0b",
                                     want.reply_kind, want.session_closed,
                                     reply_item.reply_kind, reply_item.session_closed);
                    end
                end
                stall_left = $urandom_range(0, recv_idle_max);
            end
            reply_stall <= hold_replies || (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // long hold-off of the reply side
    initial
    begin
        forever
        begin
            @(hold_go);
            hold_replies <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_replies <= 1'b0;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_commands();
        test_line_too_long();
        test_backpressure();
        test_random_sessions();
        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_replies.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
